### rtl/core/code_value_multi_format_encoder_macros.svh
// assertion helpers for the encoder checker
`ifndef CODE_VALUE_MULTI_FORMAT_ENCODER_MACROS_SVH
`define CODE_VALUE_MULTI_FORMAT_ENCODER_MACROS_SVH

// same-cycle implication, off during reset
`define CVME_ASSERT_IMPLY(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("encoder check failed");

// next-cycle implication, off during reset
`define CVME_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("encoder check failed");

// next-cycle implication, always on
`define CVME_ASSERT_NEXT_ALWAYS(label, clk, a, c) \
   label: assert property (@(posedge clk) (a) |=> (c)) \
      else $error("encoder check failed");

`endif

### rtl/core/cvme_pkg.sv
package cvme_pkg;

   localparam int VAL_W       = 64;
   localparam int GRP_W       = 7;
   // ten slots: enough for ten 7-bit groups of a 64-bit value
   localparam int MAX_BYTES   = 10;
   localparam int QUEUE_DEPTH = 2;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_ADDR_W = CSR_IDX_W + 2;

   localparam logic [CSR_IDX_W-1:0] REG_OUT_FORMAT = 1'b0;

   typedef enum logic [3:0] {
      FMT_RAW8     = 4'd0,
      FMT_RAW16_LE = 4'd1,
      FMT_RAW16_BE = 4'd2,
      FMT_RAW32_LE = 4'd3,
      FMT_RAW32_BE = 4'd4,
      FMT_RAW64_LE = 4'd5,
      FMT_RAW64_BE = 4'd6,
      FMT_UTF8     = 4'd7,
      FMT_MUTF8    = 4'd8,
      FMT_VLQ      = 4'd9,
      FMT_LEB128   = 4'd10,
      FMT_UTF16_LE = 4'd11,
      FMT_UTF16_BE = 4'd12,
      FMT_ASCII    = 4'd13
   } fmt_type;

   typedef struct packed {
      logic [MAX_BYTES-1:0][7:0] slots;
      logic [MAX_BYTES-1:0]      mask;
      logic                      err;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef struct packed {
      logic       strobe;
      logic [7:0] out_byte;
      logic       last;
      logic       error;
   } rsp_type;

endpackage

### rtl/core/cvme_front.sv
module cvme_front import cvme_pkg::*; (
   input  logic [VAL_W-1:0] code_value,
   input  fmt_type          fmt,
   output entry_type        entry,
   output logic             valid
);

   localparam int XE_W = MAX_BYTES * GRP_W;

   logic [XE_W-1:0]                 xe;
   logic [MAX_BYTES-1:0][GRP_W-1:0] grp;
   logic [MAX_BYTES-1:0]            nz;
   logic [3:0]                      ngrp;
   logic [2:0]                      cont;
   logic [7:0]                      lead;
   logic [35:0]                     xs;
   logic [19:0]                     y;
   logic [15:0]                     hi;
   logic [15:0]                     lo;

   assign xe = XE_W'(code_value);
   assign xs = code_value[35:0];
   assign y  = 20'(code_value[20:0] - 21'h10000);
   assign hi = 16'hD800 | 16'(y[19:10]);
   assign lo = 16'hDC00 | 16'(y[9:0]);

   always_comb begin
      for (int i = 0; i < MAX_BYTES; i++) begin
         grp[i] = xe[GRP_W*i +: GRP_W];
         nz[i]  = (grp[i] != '0);
      end
   end

   // highest nonzero group sets the group count, at least one
   always_comb begin
      ngrp = 4'd1;
      for (int i = 1; i < MAX_BYTES; i++) begin
         if (nz[i]) begin
            ngrp = 4'(i + 1);
         end
      end
   end

   always_comb begin
      if (code_value < 64'h800) begin
         cont = 3'd1;
      end else if (code_value < 64'h10000) begin
         cont = 3'd2;
      end else if (code_value < 64'h200000) begin
         cont = 3'd3;
      end else if (code_value < 64'h4000000) begin
         cont = 3'd4;
      end else if (code_value < 64'h80000000) begin
         cont = 3'd5;
      end else begin
         cont = 3'd6;
      end
   end

   always_comb begin
      case (cont)
         3'd1: lead = 8'hC0;
         3'd2: lead = 8'hE0;
         3'd3: lead = 8'hF0;
         3'd4: lead = 8'hF8;
         3'd5: lead = 8'hFC;
         3'd6: lead = 8'hFE;
         default: lead = 8'h00;
      endcase
   end

   always_comb begin
      entry = '0;
      case (fmt)
         FMT_RAW8: begin
            entry.slots[0] = code_value[7:0];
            entry.mask     = MAX_BYTES'(1);
         end
         FMT_RAW16_LE: begin
            for (int j = 0; j < 2; j++) entry.slots[j] = code_value[8*j +: 8];
            entry.mask = MAX_BYTES'(10'h3);
         end
         FMT_RAW16_BE: begin
            for (int j = 0; j < 2; j++) entry.slots[j] = code_value[8*(1-j) +: 8];
            entry.mask = MAX_BYTES'(10'h3);
         end
         FMT_RAW32_LE: begin
            for (int j = 0; j < 4; j++) entry.slots[j] = code_value[8*j +: 8];
            entry.mask = MAX_BYTES'(10'hF);
         end
         FMT_RAW32_BE: begin
            for (int j = 0; j < 4; j++) entry.slots[j] = code_value[8*(3-j) +: 8];
            entry.mask = MAX_BYTES'(10'hF);
         end
         FMT_RAW64_LE: begin
            for (int j = 0; j < 8; j++) entry.slots[j] = code_value[8*j +: 8];
            entry.mask = MAX_BYTES'(10'hFF);
         end
         FMT_RAW64_BE: begin
            for (int j = 0; j < 8; j++) entry.slots[j] = code_value[8*(7-j) +: 8];
            entry.mask = MAX_BYTES'(10'hFF);
         end
         FMT_UTF8, FMT_MUTF8: begin
            if (fmt == FMT_MUTF8 && code_value == '0) begin
               entry.slots[0] = 8'hC0;
               entry.slots[1] = 8'h80;
               entry.mask     = MAX_BYTES'(10'h3);
            end else if (code_value < 64'h80) begin
               entry.slots[0] = code_value[7:0];
               entry.mask     = MAX_BYTES'(1);
            end else if (code_value[VAL_W-1:36] != '0) begin
               entry.err  = 1'b1;
               entry.mask = MAX_BYTES'(1);
            end else begin
               entry.slots[0] = lead | 8'(xs >> (6 * cont));
               entry.mask[0]  = 1'b1;
               for (int j = 1; j < 7; j++) begin
                  if (j <= int'(cont)) begin
                     entry.slots[j] = {2'b10, 6'(xs >> (6 * (int'(cont) - j)))};
                     entry.mask[j]  = 1'b1;
                  end
               end
            end
         end
         FMT_VLQ: begin
            for (int j = 0; j < MAX_BYTES; j++) begin
               if (j < int'(ngrp)) begin
                  entry.slots[j] = {(j != int'(ngrp) - 1),
                                    grp[4'(int'(ngrp) - 1 - j)]};
                  entry.mask[j]  = 1'b1;
               end
            end
         end
         FMT_LEB128: begin
            for (int j = 0; j < MAX_BYTES; j++) begin
               if (j < int'(ngrp)) begin
                  entry.slots[j] = {(j < int'(ngrp) - 1), grp[j]};
                  entry.mask[j]  = 1'b1;
               end
            end
         end
         FMT_UTF16_LE, FMT_UTF16_BE: begin
            if (code_value > 64'h10FFFF) begin
               entry.err  = 1'b1;
               entry.mask = MAX_BYTES'(1);
            end else if (code_value[20:16] != '0) begin
               if (fmt == FMT_UTF16_BE) begin
                  entry.slots[0] = hi[15:8];
                  entry.slots[1] = hi[7:0];
                  entry.slots[2] = lo[15:8];
                  entry.slots[3] = lo[7:0];
               end else begin
                  entry.slots[0] = hi[7:0];
                  entry.slots[1] = hi[15:8];
                  entry.slots[2] = lo[7:0];
                  entry.slots[3] = lo[15:8];
               end
               entry.mask = MAX_BYTES'(10'hF);
            end else begin
               if (fmt == FMT_UTF16_BE) begin
                  entry.slots[0] = code_value[15:8];
                  entry.slots[1] = code_value[7:0];
               end else begin
                  entry.slots[0] = code_value[7:0];
                  entry.slots[1] = code_value[15:8];
               end
               entry.mask = MAX_BYTES'(10'h3);
            end
         end
         FMT_ASCII: begin
            for (int j = 0; j < MAX_BYTES; j++) entry.slots[j] = {1'b0, grp[j]};
            entry.mask = nz;
         end
         default: begin
            entry.err  = 1'b1;
            entry.mask = MAX_BYTES'(1);
         end
      endcase
   end

   assign valid = (entry.mask != '0);

endmodule

### rtl/core/cvme_queue.sv
module cvme_queue import cvme_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  entry_type        push_data,
   input  logic             pop,
   output entry_type        head,
   output queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head         = mem_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(DEPTH));

endmodule

### rtl/core/cvme_back.sv
module cvme_back import cvme_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  entry_type head,
   input  logic      empty,
   output logic      pop,
   output rsp_type   rsp
);

   logic [MAX_BYTES-1:0] mask_ff, mask_in;
   logic                 active_ff, active_in;
   logic                 strobe_ff, strobe_in;
   logic                 last_ff, last_in;
   logic                 error_ff, error_in;
   logic [7:0]           byte_ff, byte_in;
   logic [MAX_BYTES-1:0] cur_mask;
   logic [MAX_BYTES-1:0] pick;
   logic [MAX_BYTES-1:0] rem;
   logic                 go;
   logic                 done;

   assign go       = !empty;
   assign cur_mask = active_ff ? mask_ff : head.mask;
   // lowest pending slot
   assign pick     = cur_mask & (~cur_mask + MAX_BYTES'(1));
   assign rem      = cur_mask & ~pick;
   assign done     = (rem == '0);

   always_comb begin
      byte_in = '0;
      for (int j = 0; j < MAX_BYTES; j++) begin
         if (pick[j]) begin
            byte_in = byte_in | head.slots[j];
         end
      end
   end

   assign pop       = go && done;
   assign active_in = go && !done;
   assign mask_in   = rem;
   assign strobe_in = go;
   assign last_in   = go && done;
   assign error_in  = go && head.err;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         strobe_ff <= 1'b0;
         last_ff   <= 1'b0;
         error_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         strobe_ff <= strobe_in;
         last_ff   <= last_in;
         error_ff  <= error_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff <= mask_in;
      byte_ff <= byte_in;
   end

   assign rsp.strobe   = strobe_ff;
   assign rsp.out_byte = byte_ff;
   assign rsp.last     = last_ff;
   assign rsp.error    = error_ff;

endmodule

### rtl/core/code_value_multi_format_encoder.sv
// Encodes one 64-bit code value per request into a run of bytes, one byte per
// result cycle on rsp_strobe, with rsp_last on the final byte. The format comes
// from the out_format register (address 0). An item gives a run of 1 to 10
// bytes (raw 1/2/4/8, UTF-8 1 to 7, VLQ and LEB128 1 to 10, UTF-16 2 or 4,
// ASCII one per nonzero 7-bit group); an unencodable value gives a single
// error result, and ASCII zero gives none. The byte emitter, one byte a cycle,
// sets the rate. A request is taken in any cycle that busy is low; busy rises
// only when the request queue (QUEUE_DEPTH_P entries) is full. A request is
// queued, and its bytes are registered in the byte emitter. Results cannot be
// held off, so the receiver must take one in every cycle that rsp_strobe is high.
module code_value_multi_format_encoder import cvme_pkg::*; #(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [VAL_W-1:0]      req_code_value,
   output logic                  rsp_strobe,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_last,
   output logic                  rsp_error,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   fmt_type          fmt_ff, fmt_in;
   logic [CSR_IDX_W-1:0] csr_idx;
   logic             csr_wr;
   entry_type        front_entry;
   logic             front_valid;
   logic             push;
   logic             pop;
   entry_type        head;
   queue_status_type q_status;
   rsp_type          rsp;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      fmt_in = fmt_ff;
      if (csr_wr && csr_idx == REG_OUT_FORMAT) begin
         fmt_in = fmt_type'(csr_pwdata[3:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= FMT_UTF8;
      end else begin
         fmt_ff <= fmt_in;
      end
   end

   assign csr_prdata = (csr_idx == REG_OUT_FORMAT) ? CSR_DATA_W'(fmt_ff) : '0;

   cvme_front u_front (
      .code_value (req_code_value),
      .fmt        (fmt_ff),
      .entry      (front_entry),
      .valid      (front_valid)
   );

   assign busy = q_status.full;
   assign push = start && !busy && front_valid;

   cvme_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_entry),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   cvme_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .empty (q_status.empty),
      .pop   (pop),
      .rsp   (rsp)
   );

   assign rsp_strobe   = rsp.strobe;
   assign rsp_out_byte = rsp.out_byte;
   assign rsp_last     = rsp.last;
   assign rsp_error    = rsp.error;

endmodule

### rtl/core/cvme_checker.sv
`include "code_value_multi_format_encoder_macros.svh"

module cvme_checker (
   input logic       clock,
   input logic       reset,
   input logic       busy,
   input logic       rsp_strobe,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last,
   input logic       rsp_error
);

   // an error result is a lone zero byte
   `CVME_ASSERT_IMPLY(err_is_lone_zero, clock, reset, rsp_strobe && rsp_error, rsp_out_byte == 8'h00 && rsp_last)

   // a run of bytes has no gaps and no error inside
   `CVME_ASSERT_NEXT(run_back_to_back, clock, reset, rsp_strobe && !rsp_last, rsp_strobe && !rsp_error)

   // flags only with the strobe
   `CVME_ASSERT_IMPLY(flags_need_strobe, clock, reset, !rsp_strobe, !rsp_last && !rsp_error)

   // reset leaves the block empty and ready
   `CVME_ASSERT_NEXT_ALWAYS(reset_idle, clock, reset, !rsp_strobe && !busy)

endmodule

bind code_value_multi_format_encoder cvme_checker u_checker (.*);

### verif/testbench.sv
module testbench import cvme_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   // format code with no encoder behind it
   localparam logic [3:0] FMT_SPARE_B = 4'd15;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 1'b1;
   localparam int SETTLE_CYCLES = 30;
   localparam int RANDOM_PER_FORMAT = 22;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
      logic       error;
   } byte_result_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [VAL_W-1:0]      req_code_value = '0;
   logic                  rsp_strobe;
   logic [7:0]            rsp_out_byte;
   logic                  rsp_last;
   logic                  rsp_error;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   logic [3:0]       active_format = FMT_UTF8;
   logic [VAL_W-1:0] pending_codes[$];
   byte_result_type  expected_bytes[$];
   bit               no_gaps = 1'b0;
   int               mismatch_count = 0;
   int               requests_sent = 0;
   int               bytes_checked = 0;
   int               error_results = 0;
   logic [15:0]      formats_used = '0;

   code_value_multi_format_encoder uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_code_value (req_code_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_last       (rsp_last),
      .rsp_error      (rsp_error),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // byte run that one code value turns into under the given format
   function automatic void encode_value(input logic [63:0] x, input logic [3:0] fmt);
      logic [7:0]  run[$];
      logic [15:0] units[$];
      logic [63:0] v;
      logic [63:0] part;
      logic [15:0] hi;
      logic [15:0] lo;
      logic [7:0]  lead;
      bit          ok;
      bit          big;
      int          nb;
      int          cont;
      int          k;
      int          idx;
      ok = 1'b1;
      big = 1'b0;
      nb = 0;
      case (fmt)
         FMT_RAW8: nb = 1;
         FMT_RAW16_LE: nb = 2;
         FMT_RAW16_BE: begin
            nb = 2;
            big = 1'b1;
         end
         FMT_RAW32_LE: nb = 4;
         FMT_RAW32_BE: begin
            nb = 4;
            big = 1'b1;
         end
         FMT_RAW64_LE: nb = 8;
         FMT_RAW64_BE: begin
            nb = 8;
            big = 1'b1;
         end
         FMT_UTF8, FMT_MUTF8: begin
            if (fmt == FMT_MUTF8 && x == 64'd0) begin
               run.push_back(8'hC0);
               run.push_back(8'h80);
            end else if (x < 64'h80) begin
               run.push_back(x[7:0]);
            end else if (x >= 64'h10_0000_0000) begin
               ok = 1'b0;
            end else begin
               if (x < 64'h800) begin
                  cont = 1;
                  lead = 8'hC0;
               end else if (x < 64'h1_0000) begin
                  cont = 2;
                  lead = 8'hE0;
               end else if (x < 64'h20_0000) begin
                  cont = 3;
                  lead = 8'hF0;
               end else if (x < 64'h400_0000) begin
                  cont = 4;
                  lead = 8'hF8;
               end else if (x < 64'h8000_0000) begin
                  cont = 5;
                  lead = 8'hFC;
               end else begin
                  cont = 6;
                  lead = 8'hFE;
               end
               part = x >> (6 * cont);
               run.push_back(lead | part[7:0]);
               for (k = cont - 1; k >= 0; k--) begin
                  part = x >> (6 * k);
                  run.push_back({2'b10, part[5:0]});
               end
            end
         end
         FMT_VLQ: begin
            for (k = 63; k > 0; k -= 7) begin
               part = x >> k;
               if (part != 64'd0) run.push_back({1'b1, part[6:0]});
            end
            run.push_back({1'b0, x[6:0]});
         end
         FMT_LEB128: begin
            v = x;
            while (v > 64'h7F) begin
               run.push_back({1'b1, v[6:0]});
               v = v >> 7;
            end
            run.push_back(v[7:0]);
         end
         FMT_UTF16_LE, FMT_UTF16_BE: begin
            if (x > 64'h10_FFFF) begin
               ok = 1'b0;
            end else begin
               if ((x & 64'h1F_0000) != 64'd0) begin
                  v = x - 64'h1_0000;
                  part = v >> 10;
                  hi = part[15:0] | 16'hD800;
                  lo = {6'd0, v[9:0]} | 16'hDC00;
                  units.push_back(hi);
                  units.push_back(lo);
               end else begin
                  units.push_back(x[15:0]);
               end
               foreach (units[u]) begin
                  if (fmt == FMT_UTF16_BE) begin
                     run.push_back(units[u][15:8]);
                     run.push_back(units[u][7:0]);
                  end else begin
                     run.push_back(units[u][7:0]);
                     run.push_back(units[u][15:8]);
                  end
               end
            end
         end
         FMT_ASCII: begin
            v = x;
            while (v != 64'd0) begin
               if (v[6:0] != 7'd0) run.push_back({1'b0, v[6:0]});
               v = v >> 7;
            end
         end
         default: ok = 1'b0;
      endcase
      for (k = 0; k < nb; k++) begin
         idx = big ? nb - 1 - k : k;
         part = x >> (8 * idx);
         run.push_back(part[7:0]);
      end
      if (!ok) begin
         expected_bytes.push_back('{out_byte: 8'h00, last: 1'b1, error: 1'b1});
      end else begin
         foreach (run[r])
            expected_bytes.push_back('{out_byte: run[r], last: (r == run.size() - 1),
                                      error: 1'b0});
      end
   endfunction

   // random value of random bit length, steered toward what the format accepts
   function automatic logic [63:0] random_code(input logic [3:0] fmt);
      logic [63:0] v;
      int          len;
      int          g;
      v = {$urandom, $urandom};
      len = $urandom_range(64, 0);
      if ((fmt == FMT_UTF8 || fmt == FMT_MUTF8) && $urandom_range(9) != 0)
         len = $urandom_range(36, 0);
      if ((fmt == FMT_UTF16_LE || fmt == FMT_UTF16_BE) && $urandom_range(9) != 0)
         len = $urandom_range(21, 0);
      v = (len == 0) ? 64'd0 : v >> (64 - len);
      if ((fmt == FMT_UTF16_LE || fmt == FMT_UTF16_BE) && len <= 21 && v > 64'h10_FFFF)
         v = v % 64'h11_0000;
      if (fmt == FMT_ASCII) begin
         for (g = 0; g < 9; g++)
            if ($urandom_range(2) == 0) v[7 * g +: 7] = 7'd0;
         // top group holds only bit 63
         if ($urandom_range(2) == 0) v[63] = 1'b0;
      end
      return v;
   endfunction

   // request driver
   always @(posedge clock) begin : driver
      bit fire;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            encode_value(req_code_value, active_format);
            void'(pending_codes.pop_front());
            requests_sent++;
         end
         if (!(start && busy)) begin
            fire = pending_codes.size() != 0 && (no_gaps || $urandom_range(99) >= 10);
            start <= fire;
            if (fire) req_code_value <= pending_codes[0];
         end
      end
   end

   // byte monitor
   always @(posedge clock) begin : monitor
      byte_result_type want;
      if (!reset && rsp_strobe) begin
         bytes_checked++;
         if (rsp_error) error_results++;
         if (expected_bytes.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result byte %02h last %0b error %0b", $time,
                     rsp_out_byte, rsp_last, rsp_error);
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_out_byte !== want.out_byte) begin
               mismatch_count++;
               $display("%0t: out_byte expected %02h actual %02h", $time, want.out_byte,
                        rsp_out_byte);
            end
            if (rsp_last !== want.last) begin
               mismatch_count++;
               $display("%0t: last expected %0b actual %0b", $time, want.last, rsp_last);
            end
            if (rsp_error !== want.error) begin
               mismatch_count++;
               $display("%0t: error expected %0b actual %0b", $time, want.error, rsp_error);
            end
         end
      end
   end

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [3:0] fmt);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {$urandom} & ~32'hF | {28'd0, fmt};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == REG_OUT_FORMAT) begin
         active_format = fmt;
         formats_used[fmt] = 1'b1;
      end
   endtask

   task automatic csr_check_format();
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {REG_OUT_FORMAT, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[3:0] !== active_format) begin
         mismatch_count++;
         $display("%0t: out_format readback expected %0d actual %0d", $time, active_format,
                  csr_prdata[3:0]);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // let every queued request go out and every byte come back
   task automatic settle();
      while (pending_codes.size() != 0 || start || expected_bytes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : main
      int f;
      int n;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      formats_used[FMT_UTF8] = 1'b1;
      csr_check_format();

      // utf-8 length boundaries, top of range and overflow
      pending_codes = '{64'h0, 64'h7F, 64'h80, 64'h7FF, 64'h800, 64'hFFFF, 64'h1_0000,
                        64'h1F_FFFF, 64'h20_0000, 64'h3FF_FFFF, 64'h400_0000,
                        64'h7FFF_FFFF, 64'h8000_0000, 64'hF_FFFF_FFFF,
                        64'h10_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF};
      settle();
      csr_write(REG_OUT_FORMAT, FMT_MUTF8);
      csr_check_format();
      pending_codes = '{64'h0, 64'h7F};
      settle();
      // utf-16 limit, overflow, surrogate pass-through, first pair
      csr_write(REG_OUT_FORMAT, FMT_UTF16_LE);
      pending_codes = '{64'h10_FFFF, 64'h11_0000, 64'hD800, 64'hDFFF, 64'h1_0000};
      settle();
      csr_write(REG_OUT_FORMAT, FMT_ASCII);
      pending_codes = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF};
      settle();
      // write to a nonexistent register must not touch the format
      csr_write(REG_SPARE, FMT_RAW8);
      csr_check_format();
      csr_write(REG_OUT_FORMAT, FMT_SPARE_B);
      pending_codes = '{64'h1234};
      settle();

      for (f = 0; f < 16; f++) begin
         csr_write(REG_OUT_FORMAT, f[3:0]);
         csr_check_format();
         no_gaps = (f[3:0] == FMT_VLQ || f[3:0] == FMT_LEB128);
         for (n = 0; n < RANDOM_PER_FORMAT; n++)
            pending_codes.push_back(random_code(f[3:0]));
         settle();
      end
      no_gaps = 1'b0;

      $display("requests %0d, bytes checked %0d (%0d error results)", requests_sent,
               bytes_checked, error_results);
      $display("format codes exercised: %0d of 16, including unused codes",
               $countones(formats_used));
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin : watchdog
      #(2_000_000);
      $display("timeout with %0d requests pending, %0d bytes outstanding",
               pending_codes.size(), expected_bytes.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
